### sv/cags_pkg.sv
package cags_pkg;

    // window geometry
    localparam int MAX_WINDOW = 5;
    localparam int WIN_W      = MAX_WINDOW - 1;
    localparam int IDX_W      = MAX_WINDOW;
    localparam int RULE_W     = 1 << MAX_WINDOW;
    localparam int PCOUNT_W   = 3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PARENT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_WORD    = 2'd1;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_RULE = 2'd1,
        FAULT_EVEN = 2'd2
    } fault_t;

    // what the back end does with a queued request
    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_PASS    = 2'd1,
        OP_CELL    = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     cell_bit;
        logic     last;
        logic     first;
        fault_t   fault;
    } op_t;

    typedef struct packed {
        logic [PCOUNT_W-1:0] parent_count;
        logic [RULE_W-1:0]   rule_word;
        logic                rule_ok;
    } cfg_t;

    // rule must fit in 2^parent_count bits and parent_count must be in range
    function automatic logic rule_is_valid(logic [PCOUNT_W-1:0] p, logic [RULE_W-1:0] rule);
        logic ok;
        begin
            case (p)
                3'd1:    ok = (rule[RULE_W-1:2] == '0);
                3'd2:    ok = (rule[RULE_W-1:4] == '0);
                3'd3:    ok = (rule[RULE_W-1:8] == '0);
                3'd4:    ok = (rule[RULE_W-1:16] == '0);
                3'd5:    ok = 1'b1;
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

### sv/cags_front.sv
module cags_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_cmd,
    input  logic              s_cell_in,
    input  logic              s_last_in,
    input  logic              rule_ok,
    input  logic              push_ready,
    output logic              push_valid,
    output cags_pkg::op_t     push_op
);

    logic mid_reg, mid_next;
    logic odd_reg, odd_next;
    logic accept;
    logic parity;

    assign accept     = s_valid && push_ready;
    assign push_valid = s_valid;

    // classify the request and track generation length parity
    always_comb begin
        mid_next          = mid_reg;
        odd_next          = odd_reg;
        parity            = mid_reg ? ~odd_reg : 1'b1;
        push_op.kind      = cags_pkg::OP_CELL;
        push_op.cell_bit  = s_cell_in;
        push_op.last      = s_last_in;
        push_op.first     = ~mid_reg;
        push_op.fault     = cags_pkg::FAULT_NONE;
        if (s_cmd) begin
            push_op.kind     = cags_pkg::OP_RESTART;
            push_op.cell_bit = rule_ok;
            push_op.last     = 1'b1;
            push_op.fault    = rule_ok ? cags_pkg::FAULT_NONE : cags_pkg::FAULT_RULE;
            mid_next         = 1'b0;
            odd_next         = 1'b0;
        end else if (!rule_ok) begin
            push_op.kind     = cags_pkg::OP_PASS;
            push_op.cell_bit = 1'b0;
            push_op.fault    = cags_pkg::FAULT_RULE;
            mid_next         = ~s_last_in;
            odd_next         = s_last_in ? 1'b0 : parity;
        end else if (!s_last_in) begin
            mid_next = 1'b1;
            odd_next = parity;
        end else begin
            mid_next = 1'b0;
            odd_next = 1'b0;
            if (!parity) begin
                push_op.kind     = cags_pkg::OP_PASS;
                push_op.cell_bit = 1'b0;
                push_op.fault    = cags_pkg::FAULT_EVEN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg <= 1'b0;
            odd_reg <= 1'b0;
        end else if (accept) begin
            mid_reg <= mid_next;
            odd_reg <= odd_next;
        end
    end

endmodule

### sv/cags_queue.sv
module cags_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  cags_pkg::op_t push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cags_pkg::op_t pop_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cags_pkg::op_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = mem[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### sv/cags_back.sv
module cags_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  cags_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  cags_pkg::op_t  head_op,
    output logic           head_ready,
    output logic           draining,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_cell_out,
    output logic           m_last_out,
    output logic [1:0]     m_fault
);

    localparam int WIN_W    = cags_pkg::WIN_W;
    localparam int IDX_W    = cags_pkg::IDX_W;
    localparam int PCOUNT_W = cags_pkg::PCOUNT_W;

    logic [WIN_W-1:0]    win_reg, win_next;
    logic                outer_reg, outer_next;
    logic [PCOUNT_W-1:0] drain_reg, drain_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_cell_reg, m_last_reg;
    cags_pkg::fault_t    m_fault_reg;

    logic [IDX_W:0]      span;
    logic [IDX_W-1:0]    imask;
    logic [WIN_W-1:0]    wmask;
    logic [IDX_W-1:0]    all_idx;
    logic                outer_rule;
    logic                out_free;
    logic [WIN_W-1:0]    feed_base;
    logic                feed_cell;
    logic [IDX_W-1:0]    idx;
    logic                fed_bit;
    logic [WIN_W-1:0]    win_fed;
    logic                emit;
    logic                e_cell, e_last;
    cags_pkg::fault_t    e_fault;

    assign draining   = (drain_reg != '0);
    assign out_free   = !m_valid_reg || m_ready;
    assign head_ready = out_free && !draining;

    // window masks for the current parent count
    always_comb begin
        span       = (IDX_W + 1)'(1) << cfg.parent_count;
        imask      = IDX_W'(span - 1'b1);
        wmask      = imask[IDX_W-1:1];
        all_idx    = outer_reg ? imask : '0;
        outer_rule = cfg.rule_word[all_idx];
    end

    // shift one parent cell into the window and look up the rule bit
    always_comb begin
        if (draining) begin
            feed_base = win_reg;
            feed_cell = outer_reg;
        end else begin
            feed_base = head_op.first ? (outer_reg ? wmask : '0) : win_reg;
            feed_cell = head_op.cell_bit;
        end
        idx     = {feed_base, feed_cell} & imask;
        fed_bit = cfg.rule_word[idx];
        win_fed = idx[WIN_W-1:0] & wmask;
    end

    // carry out the head request or the next drain cell
    always_comb begin
        win_next   = win_reg;
        outer_next = outer_reg;
        drain_next = drain_reg;
        emit       = 1'b0;
        e_cell     = 1'b0;
        e_last     = 1'b0;
        e_fault    = cags_pkg::FAULT_NONE;
        if (out_free) begin
            if (draining) begin
                emit       = 1'b1;
                e_cell     = fed_bit;
                e_last     = (drain_reg == PCOUNT_W'(1));
                win_next   = win_fed;
                drain_next = drain_reg - 1'b1;
                if (drain_reg == PCOUNT_W'(1)) begin
                    outer_next = outer_rule;
                    win_next   = '0;
                end
            end else if (head_valid) begin
                emit = 1'b1;
                case (head_op.kind)
                    cags_pkg::OP_RESTART: begin
                        outer_next = 1'b0;
                        win_next   = '0;
                        e_cell     = head_op.cell_bit;
                        e_last     = 1'b1;
                        e_fault    = head_op.fault;
                    end
                    cags_pkg::OP_PASS: begin
                        e_cell  = head_op.cell_bit;
                        e_last  = head_op.last;
                        e_fault = head_op.fault;
                        // a closing request ends the generation with an empty window
                        if (head_op.last) begin
                            win_next = '0;
                        end
                    end
                    cags_pkg::OP_CELL: begin
                        e_cell   = fed_bit;
                        win_next = win_fed;
                        if (head_op.last) begin
                            e_last     = (cfg.parent_count == PCOUNT_W'(1));
                            drain_next = cfg.parent_count - 1'b1;
                            if (cfg.parent_count == PCOUNT_W'(1)) begin
                                outer_next = outer_rule;
                                win_next   = '0;
                            end
                        end
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
        m_valid_next = out_free ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            outer_reg   <= 1'b0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            outer_reg   <= outer_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_cell_reg  <= e_cell;
            m_last_reg  <= e_last;
            m_fault_reg <= e_fault;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_cell_out = m_cell_reg;
    assign m_last_out = m_last_reg;
    assign m_fault    = m_fault_reg;

endmodule

### sv/cellular_automaton_generation_step_unit.sv
// path: an accepted request is stored in the request queue, then the back end registers its first result
// throughput: one cell per cycle unless m_ready is low; a last cell occupies the back end
// while it drains the trailing cells; the request queue takes up to QUEUE_DEPTH requests
// meanwhile and the input then stalls until the drain ends
// reset: synchronous, active-low aresetn clears the queue, window, outer bit and parity,
// and sets parent_count to 3 and rule_word to 0
module cellular_automaton_generation_step_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic                             s_cell_in,
    input  logic                             s_last_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_cell_out,
    output logic                             m_last_out,
    output logic [1:0]                       m_fault,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cags_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cags_pkg::RULE_W-1:0]      cfg_data
);

    logic [cags_pkg::PCOUNT_W-1:0] pcount_reg, pcount_next;
    logic [cags_pkg::RULE_W-1:0]   rule_reg, rule_next;
    cags_pkg::cfg_t                cfg;
    logic                          push_valid;
    cags_pkg::op_t                 push_op;
    logic                          head_valid;
    logic                          head_ready;
    cags_pkg::op_t                 head_op;
    logic                          draining;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_comb begin
        pcount_next = pcount_reg;
        rule_next   = rule_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cags_pkg::REG_PARENT_COUNT: pcount_next = cfg_data[cags_pkg::PCOUNT_W-1:0];
                cags_pkg::REG_RULE_WORD:    rule_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= cags_pkg::PCOUNT_W'(3);
            rule_reg   <= '0;
        end else begin
            pcount_reg <= pcount_next;
            rule_reg   <= rule_next;
        end
    end

    assign cfg.parent_count = pcount_reg;
    assign cfg.rule_word    = rule_reg;
    assign cfg.rule_ok      = cags_pkg::rule_is_valid(pcount_reg, rule_reg);

    cags_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_cmd      (s_cmd),
        .s_cell_in  (s_cell_in),
        .s_last_in  (s_last_in),
        .rule_ok    (cfg.rule_ok),
        .push_ready (s_ready),
        .push_valid (push_valid),
        .push_op    (push_op)
    );

    cags_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (s_ready),
        .push_op    (push_op),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_op     (head_op)
    );

    cags_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_op    (head_op),
        .head_ready (head_ready),
        .draining   (draining),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_out (m_cell_out),
        .m_last_out (m_last_out),
        .m_fault    (m_fault)
    );

    // no new request is taken from the queue while trailing cells drain
    assert property (@(posedge aclk) disable iff (!aresetn) draining |-> !head_ready)
        else $error("queue popped during drain");

    // a faulted result never carries a live cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault != cags_pkg::FAULT_NONE) |-> !m_cell_out)
        else $error("live cell on faulted result");

    // an even-length fault always closes the generation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault == cags_pkg::FAULT_EVEN) |-> m_last_out)
        else $error("even-length fault without last");

    // the drain ends on a last cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (draining && m_ready && m_valid) |=> (draining || (m_valid && m_last_out)))
        else $error("drain ended without last cell");

endmodule

### tb/cags_tb_pkg.sv
package cags_tb_pkg;

    // request command codes
    localparam logic CMD_CELL    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

endpackage

### tb/cags_checker.sv
module cags_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_cmd,
    input  logic                        s_cell_in,
    input  logic                        s_last_in,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_cell_out,
    input  logic                        m_last_out,
    input  logic [1:0]                  m_fault,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [cags_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cags_pkg::RULE_W-1:0]      cfg_data,
    output int                          err_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             cell_bit;
        logic             last;
        cags_pkg::fault_t fault;
    } gen_cell_t;

    // expected cells of the next generation, oldest first
    gen_cell_t next_gen_q[$];

    // shadow of the registers and of the generation state
    logic [cags_pkg::PCOUNT_W-1:0] pcount;
    logic [cags_pkg::RULE_W-1:0]   rule;
    logic [cags_pkg::WIN_W-1:0]    win;
    logic                          outer;
    logic                          odd_len;
    logic                          mid_gen;
    int                            errs = 0;

    function automatic void push_cell(input logic c, input logic l,
                                      input cags_pkg::fault_t f);
        gen_cell_t g;
        g.cell_bit = c;
        g.last     = l;
        g.fault    = f;
        next_gen_q.insert(next_gen_q.size(), g);
    endfunction

    // shift one parent into the window and look up the rule bit
    function automatic logic shift_cell(input logic c);
        int idx;
        idx = ((win << 1) | c) & ((1 << pcount) - 1);
        win = cags_pkg::WIN_W'(idx & ((1 << (pcount - 1)) - 1));
        return rule[idx];
    endfunction

    task automatic predict_next_cells(input logic cmd, input logic cell_bit,
                                      input logic last);
        logic ok;
        int   p;
        int   k;
        ok = (pcount != 3'd0) && (pcount <= cags_pkg::MAX_WINDOW)
             && (({32'd0, rule} >> (1 << pcount)) == 64'd0);
        p = pcount;
        if (cmd == cags_tb_pkg::CMD_RESTART) begin
            outer   = 1'b0;
            win     = '0;
            odd_len = 1'b0;
            mid_gen = 1'b0;
            if (ok) push_cell(1'b1, 1'b1, cags_pkg::FAULT_NONE);
            else    push_cell(1'b0, 1'b1, cags_pkg::FAULT_RULE);
        end else if (!ok) begin
            // bad rule: one faulted cell per request, outer bit kept
            push_cell(1'b0, last, cags_pkg::FAULT_RULE);
            if (last) begin
                mid_gen = 1'b0;
                odd_len = 1'b0;
                win     = '0;
            end else begin
                odd_len = mid_gen ? ~odd_len : 1'b1;
                mid_gen = 1'b1;
            end
        end else begin
            // window preloaded with the outer bit on the first cell
            if (!mid_gen) begin
                win     = outer ? cags_pkg::WIN_W'((1 << (p - 1)) - 1) : '0;
                odd_len = 1'b1;
                mid_gen = 1'b1;
            end else begin
                odd_len = ~odd_len;
            end
            if (!last) begin
                push_cell(shift_cell(cell_bit), 1'b0, cags_pkg::FAULT_NONE);
            end else begin
                mid_gen = 1'b0;
                if (!odd_len) begin
                    win = '0;
                    push_cell(1'b0, 1'b1, cags_pkg::FAULT_EVEN);
                end else begin
                    // last cell then drain with the outer bit
                    push_cell(shift_cell(cell_bit), p == 1, cags_pkg::FAULT_NONE);
                    for (k = 1; k < p; k++) begin
                        push_cell(shift_cell(outer), k == p - 1, cags_pkg::FAULT_NONE);
                    end
                    outer   = rule[outer ? (1 << p) - 1 : 0];
                    win     = '0;
                    odd_len = 1'b0;
                end
            end
        end
    endtask

    // watch all three channels
    always @(posedge aclk) begin : watch
        gen_cell_t want;
        if (!aresetn) begin
            pcount  = 3'd3;
            rule    = '0;
            win     = '0;
            outer   = 1'b0;
            odd_len = 1'b0;
            mid_gen = 1'b0;
            next_gen_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == cags_pkg::REG_PARENT_COUNT)
                    pcount = cfg_data[cags_pkg::PCOUNT_W-1:0];
                else if (cfg_index == cags_pkg::REG_RULE_WORD)
                    rule = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (next_gen_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result: cell %0b last %0b fault %0d",
                                 m_cell_out, m_last_out, m_fault);
                end else begin
                    want = next_gen_q.pop_front();
                    if (m_cell_out !== want.cell_bit || m_last_out !== want.last
                        || m_fault !== want.fault) begin
                        errs++;
                        if (errs <= 10)
                            $display("expected cell/last/fault %0b %0b %0d, got %0b %0b %0d",
                                     want.cell_bit, want.last, want.fault,
                                     m_cell_out, m_last_out, m_fault);
                    end
                end
            end
            if (s_valid && s_ready) predict_next_cells(s_cmd, s_cell_in, s_last_in);
        end
        err_count <= errs;
        pending   <= next_gen_q.size();
    end

endmodule

### tb/tb_cellular_automaton_generation_step_unit.sv
module tb_cellular_automaton_generation_step_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_cmd;
    logic                             s_cell_in;
    logic                             s_last_in;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_cell_out;
    logic                             m_last_out;
    logic [1:0]                       m_fault;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [cags_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cags_pkg::RULE_W-1:0]      cfg_data;

    int err_count;
    int pending;
    int cycles = 0;
    int rx_hold;
    bit quiet = 1'b0;

    cellular_automaton_generation_step_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_cell_in  (s_cell_in),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_out (m_cell_out),
        .m_last_out (m_last_out),
        .m_fault    (m_fault),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    cags_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_cell_in  (s_cell_in),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cell_out (m_cell_out),
        .m_last_out (m_last_out),
        .m_fault    (m_fault),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .err_count  (err_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run time guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // result side: stall for a fresh number of cycles after each result
    always @(posedge aclk) begin : rx_stall
        int hold;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else begin
            hold = (m_valid && m_ready) ? draw_wait() : rx_hold;
            if (hold > 0) begin
                m_ready <= 1'b0;
                rx_hold <= hold - 1;
            end else begin
                m_ready <= 1'b1;
                rx_hold <= 0;
            end
        end
    end

    // one request, valid held until accepted
    task automatic send_request(input logic cmd, input logic cell_bit, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_cell_in <= cell_bit;
        s_last_in <= last;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
    endtask

    task automatic send_generation(input int len, input logic [15:0] cells);
        int i;
        for (i = 0; i < len; i++) send_request(cags_tb_pkg::CMD_CELL, cells[i], i == len - 1);
    endtask

    // drop valid and let every expected cell come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        forever begin
            @(negedge aclk);
            if (pending == 0) break;
        end
        repeat (4) @(posedge aclk);
    endtask

    // write both registers back to back
    task automatic load_rule(input logic [cags_pkg::PCOUNT_W-1:0] pc,
                             input logic [cags_pkg::RULE_W-1:0] rule);
        cfg_valid <= 1'b1;
        cfg_index <= cags_pkg::REG_PARENT_COUNT;
        cfg_data  <= cags_pkg::RULE_W'(pc);
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
        cfg_index <= cags_pkg::REG_RULE_WORD;
        cfg_data  <= rule;
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int                            phase;
        int                            budget;
        int                            sent;
        int                            pick;
        int                            len;
        logic [cags_pkg::PCOUNT_W-1:0] pc;
        logic [63:0]                   mask;
        logic [cags_pkg::RULE_W-1:0]   rule;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_cmd     <= cags_tb_pkg::CMD_CELL;
        s_cell_in <= 1'b0;
        s_last_in <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= cags_pkg::REG_PARENT_COUNT;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // three parents, rule 30: seed, single cell, short generation
        load_rule(3'd3, 32'd30);
        send_request(cags_tb_pkg::CMD_RESTART, 1'b0, 1'b0);
        send_generation(1, 16'h0001);
        send_generation(3, 16'h0005);
        // restart dropping a generation in progress
        send_request(cags_tb_pkg::CMD_CELL, 1'b1, 1'b0);
        send_request(cags_tb_pkg::CMD_RESTART, 1'b1, 1'b1);
        // even length generation
        send_generation(2, 16'h0003);
        wait_idle();

        // rule wider than the window allows
        load_rule(3'd3, 32'hFFFF_FFFF);
        send_request(cags_tb_pkg::CMD_CELL, 1'b0, 1'b0);
        send_request(cags_tb_pkg::CMD_CELL, 1'b1, 1'b1);
        send_request(cags_tb_pkg::CMD_RESTART, 1'b0, 1'b1);
        wait_idle();

        // widest window, all ones: longest drain, outer bit turns to one
        load_rule(3'd5, 32'hFFFF_FFFF);
        send_generation(1, 16'h0000);
        send_generation(1, 16'h0000);
        wait_idle();

        // single parent, inverting rule
        load_rule(3'd1, 32'd1);
        send_generation(1, 16'h0001);
        send_generation(3, 16'h0002);
        wait_idle();

        // parent count out of range at both ends
        load_rule(3'd0, 32'd0);
        send_request(cags_tb_pkg::CMD_CELL, 1'b0, 1'b1);
        wait_idle();
        load_rule(3'd7, 32'd0);
        send_request(cags_tb_pkg::CMD_RESTART, 1'b1, 1'b0);

        // random phases, one register setting each
        for (phase = 0; phase < 10; phase++) begin
            wait_idle();
            quiet = (phase % 3 == 1);
            case (phase)
                0, 6:    pc = 3'd3;
                1, 5:    pc = 3'd5;
                2:       pc = 3'd1;
                3, 7:    pc = 3'd2;
                4:       pc = 3'd4;
                8:       pc = 3'd6;
                default: pc = 3'd3;
            endcase
            mask = (64'd1 << (1 << pc)) - 64'd1;
            rule = $urandom & mask[31:0];
            if (phase == 1) rule = '1;
            if (phase == 7) rule = '0;
            if (phase == 9) rule = rule | 32'h0000_0100;
            load_rule(pc, rule);
            budget = (phase >= 8) ? 14 : 38;
            sent   = 0;
            while (sent < budget) begin
                pick = $urandom_range(0, 15);
                if (pick == 0) begin
                    send_request(cags_tb_pkg::CMD_RESTART, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    sent++;
                end else if (pick == 1) begin
                    // noise request
                    send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    if (pick == 2)      len = 2 * $urandom_range(1, 3);
                    else if (pick == 3) len = 2 * $urandom_range(5, 7) + 1;
                    else                len = 2 * $urandom_range(0, 3) + 1;
                    send_generation(len, 16'($urandom));
                    sent += len;
                end
            end
        end

        quiet = 1'b0;
        wait_idle();
        repeat (12) @(posedge aclk);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
sv/cags_pkg.sv
sv/cags_front.sv
sv/cags_queue.sv
sv/cags_back.sv
sv/cellular_automaton_generation_step_unit.sv
tb/cags_tb_pkg.sv
tb/cags_checker.sv
tb/tb_cellular_automaton_generation_step_unit.sv
